>>> hw/rtl/lsh_pkg.sv
// Shared constants for the distance level-of-detail selector.
`default_nettype none
package lsh_pkg;
    localparam int MAX_LEVELS = 4;
    localparam int SUM_W      = 50;
    localparam int ROOT_W     = 25;
    localparam int BAND_W     = 46;
    localparam int REM_W      = 48;
    localparam int Q_W        = 17;
    localparam int MA_W       = 28;
    localparam int MB_W       = 25;
    localparam int PROD_W     = MA_W + MB_W;

    localparam logic [BAND_W-1:0] BAND_MIN  = BAND_W'(16777);
    localparam logic [MB_W-1:0]   HYST_UP   = MB_W'(72090);
    localparam logic [MB_W-1:0]   HYST_DOWN = MB_W'(58982);
    localparam logic [16:0]       FADE_MIN  = 17'd66;
    localparam logic [16:0]       FADE_MAX  = 17'd65536;

    localparam logic [2:0] REG_LEVEL_COUNT     = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_COUNT = 3'd1;
    localparam logic [2:0] REG_THRESHOLD_0     = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_1     = 3'd3;
    localparam logic [2:0] REG_THRESHOLD_2     = 3'd4;
    localparam logic [2:0] REG_THRESHOLD_3     = 3'd5;
    localparam logic [2:0] REG_FADE_WIDTH      = 3'd6;
    localparam logic [2:0] REG_CROSSFADE_EN    = 3'd7;

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;
endpackage
`default_nettype wire

>>> hw/rtl/lsh_in_if.sv
// Request channel carrying camera and object coordinates.
`default_nettype none
interface lsh_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic signed [23:0] cam_z;
    logic signed [23:0] obj_x;
    logic signed [23:0] obj_y;
    logic signed [23:0] obj_z;
    modport source (output valid, cam_x, cam_y, cam_z, obj_x, obj_y, obj_z, input ready);
    modport sink   (input valid, cam_x, cam_y, cam_z, obj_x, obj_y, obj_z, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsh_out_if.sv
// Result channel carrying the selected level and blend data.
`default_nettype none
interface lsh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  level;
    logic        fade_active;
    logic [1:0]  fade_finer;
    logic [1:0]  fade_coarser;
    logic [16:0] fade_factor;
    modport source (output valid, level, fade_active, fade_finer, fade_coarser, fade_factor,
                    input ready);
    modport sink   (input valid, level, fade_active, fade_finer, fade_coarser, fade_factor,
                    output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsh_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module lsh_isqrt import lsh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);
    logic             r_busy;
    logic [4:0]       r_k;
    logic [SUM_W-1:0] r_n;
    logic [SUM_W-1:0] r_root;
    logic [SUM_W-1:0] w_bit;
    logic [SUM_W-1:0] w_try;

    assign w_bit  = SUM_W'(1) << {r_k, 1'b0};
    assign w_try  = r_root + w_bit;
    assign o_root = r_root[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_k    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 5'd24;
                r_n    <= i_val;
                r_root <= '0;
            end else if (r_busy) begin
                if (r_n >= w_try) begin
                    r_n    <= r_n - w_try;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_k <= r_k - 5'd1;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lsh_div.sv
// Iterative restoring divider giving a Q1.16 fraction of num over den.
`default_nettype none
module lsh_div import lsh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BAND_W-1:0] i_num,
    input  logic [BAND_W-1:0] i_den,
    output logic              o_done,
    output logic [Q_W-1:0]    o_q
);
    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_den;
    logic             w_ge;

    assign w_ge = r_rem >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(Q_W - 1);
                r_rem  <= REM_W'(i_num);
                r_den  <= REM_W'(i_den);
                o_q    <= '0;
            end else if (r_busy) begin
                o_q   <= {o_q[Q_W-2:0], w_ge};
                r_rem <= (w_ge ? r_rem - r_den : r_rem) << 1;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lod_select_hysteresis_crossfade.sv
// Top level: sequencer around a shared multiplier, square root and divider.
//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | cam_x..z, obj_x..z (signed Q16.8)
//  o_out    | out | valid / ready | level, fade_active/finer/coarser/factor
//  i_cfg_*  | in  | write enable  | register index, 24-bit data
// The 25-step square root and, when a blend band is hit, the 17-step divide dominate
// the time one request takes.
// Input ready is high only while idle; a waiting result holds the sequencer.
// Synchronous active-low reset restores register defaults and level zero.
`default_nettype none
module lod_select_hysteresis_crossfade import lsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    lsh_in_if.sink      i_in,
    lsh_out_if.source   o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_RTW, S_BO, S_BI, S_BIS, S_CMP, S_DIV, S_DIVW,
        S_HY, S_HYM, S_HYC, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]  r_lc, r_tc;
    logic [23:0] r_thr [MAX_LEVELS];
    logic [16:0] r_fw;
    logic        r_cfe;

    logic signed [23:0] r_c [3];
    logic signed [23:0] r_o [3];
    logic [1:0]         r_cnt;
    logic [SUM_W-1:0]   r_sum;
    logic [PROD_W-1:0]  r_prod;
    logic [23:0]        r_d;
    logic [1:0]         r_i;
    logic [BAND_W-1:0]  r_bo, r_bi, r_num, r_den;
    logic               r_act;
    logic [1:0]         r_fin, r_coa;
    logic [16:0]        r_fac;
    logic [1:0]         r_cur, r_des, r_bnd;
    logic               r_up;
    logic               r_ovalid;

    logic [2:0]  w_nl, w_nt, w_lim;
    logic [16:0] w_w;
    logic        w_cf;
    logic [MA_W-1:0] w_ma;
    logic [MB_W-1:0] w_mb;
    logic signed [24:0] w_diff;
    logic [23:0] w_mag;
    t_unit_ctl   w_sq_ctl, w_dv_ctl;
    logic [ROOT_W-1:0] w_root;
    logic [16:0] w_q;
    logic signed [25:0] w_t, w_prev, w_next, w_sego, w_s;
    logic signed [29:0] w_segi;
    logic        w_last;
    logic [BAND_W-1:0] w_band;
    logic signed [48:0] w_d24, w_t24, w_lo, w_hi;
    logic        w_in1, w_in2, w_more;
    logic [1:0]  w_des, w_i1;
    logic        w_found;
    logic [23:0] w_bthr;
    logic [39:0] w_ds;

    assign w_nl  = (r_lc == 3'd0) ? 3'd1 : ((r_lc > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : r_lc);
    assign w_nt  = (r_tc > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : r_tc;
    assign w_lim = (w_nt < w_nl) ? w_nt : w_nl;
    assign w_w   = (r_fw < FADE_MIN) ? FADE_MIN : ((r_fw > FADE_MAX) ? FADE_MAX : r_fw);
    assign w_cf  = r_cfe && (w_nl >= 3'd2) && (w_nt != 3'd0);

    assign w_diff = 25'(r_o[r_cnt]) - 25'(r_c[r_cnt]);
    assign w_mag  = w_diff[24] ? 24'(-w_diff) : w_diff[23:0];

    assign w_i1   = r_i + 2'd1;
    assign w_t    = 26'({1'b0, r_thr[r_i]});
    assign w_prev = (r_i == 2'd0) ? 26'sd0 : 26'({1'b0, r_thr[r_i - 2'd1]});
    assign w_next = 26'({1'b0, r_thr[w_i1]});
    assign w_last = {1'b0, w_i1} >= w_nt;
    assign w_sego = w_t - w_prev;
    assign w_s    = (w_sego < 26'sd256) ? 26'sd256 : w_sego;
    assign w_segi = w_last ? 30'(w_s) * 30'sd10 : 30'(w_next - w_t);

    always_comb begin
        if (r_state == S_BI) begin
            w_band = (w_sego <= 26'sd0 || r_prod[BAND_W-1:0] < BAND_MIN)
                ? BAND_MIN : r_prod[BAND_W-1:0];
        end else begin
            w_band = (w_segi <= 30'sd0 || r_prod[BAND_W-1:0] < BAND_MIN)
                ? BAND_MIN : r_prod[BAND_W-1:0];
        end
    end

    assign w_d24 = 49'({r_d, 16'd0});
    assign w_t24 = 49'({r_thr[r_i], 16'd0});
    assign w_lo  = w_t24 - 49'(r_bo);
    assign w_hi  = w_t24 + 49'(r_bi);
    assign w_in1 = (w_d24 > w_lo) && (w_d24 <= w_t24);
    assign w_in2 = (w_d24 > w_t24) && (w_d24 <= w_hi);
    assign w_more = ({1'b0, w_i1} + 3'd1 < w_nl) && ({1'b0, w_i1} < w_nt);

    always_comb begin
        w_des   = 2'(w_nl - 3'd1);
        w_found = 1'b0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (!w_found && 3'(k) < w_lim && r_d <= r_thr[k]) begin
                w_des   = 2'(k);
                w_found = 1'b1;
            end
        end
    end

    assign w_bthr = r_thr[r_bnd];
    assign w_ds   = {r_d, 16'd0};

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQ: begin
                w_ma = MA_W'(w_mag);
                w_mb = MB_W'(w_mag);
            end
            S_BO: begin
                w_ma = MA_W'(w_sego);
                w_mb = MB_W'(w_w);
            end
            S_BI: begin
                w_ma = w_segi[MA_W-1:0];
                w_mb = MB_W'(w_w);
            end
            S_HYM: begin
                w_ma = MA_W'(w_bthr);
                w_mb = r_up ? HYST_UP : HYST_DOWN;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_sq_ctl.start = (r_state == S_ROOT);
    assign w_dv_ctl.start = (r_state == S_DIV);

    lsh_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_ctl.start),
        .i_val   (r_sum),
        .o_done  (w_sq_ctl.done),
        .o_root  (w_root)
    );

    lsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_ctl.start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_dv_ctl.done),
        .o_q     (w_q)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_ma) * PROD_W'(w_mb);
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lc     <= 3'd1;
            r_tc     <= 3'd0;
            for (int k = 0; k < MAX_LEVELS; k++) begin
                r_thr[k] <= '0;
            end
            r_fw     <= 17'd6554;
            r_cfe    <= 1'b0;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_LEVEL_COUNT:     r_lc <= i_cfg_data[2:0];
                    REG_THRESHOLD_COUNT: r_tc <= i_cfg_data[2:0];
                    REG_THRESHOLD_0:     r_thr[0] <= i_cfg_data;
                    REG_THRESHOLD_1:     r_thr[1] <= i_cfg_data;
                    REG_THRESHOLD_2:     r_thr[2] <= i_cfg_data;
                    REG_THRESHOLD_3:     r_thr[3] <= i_cfg_data;
                    REG_FADE_WIDTH:      r_fw <= {i_cfg_data[16:0]};
                    REG_CROSSFADE_EN:    r_cfe <= i_cfg_data[0];
                    default:             r_cfe <= r_cfe;
                endcase
            end
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_c[0] <= i_in.cam_x;
                        r_c[1] <= i_in.cam_y;
                        r_c[2] <= i_in.cam_z;
                        r_o[0] <= i_in.obj_x;
                        r_o[1] <= i_in.obj_y;
                        r_o[2] <= i_in.obj_z;
                        r_cnt  <= '0;
                        r_sum  <= '0;
                        r_act  <= 1'b0;
                        r_fin  <= '0;
                        r_coa  <= '0;
                        r_fac  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 2'd0) begin
                        r_sum <= r_sum + SUM_W'(r_prod);
                    end
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: r_state <= S_RTW;
                S_RTW: begin
                    if (w_sq_ctl.done) begin
                        r_d   <= (w_root > ROOT_W'(24'hFFFFFF)) ? 24'hFFFFFF : w_root[23:0];
                        r_i   <= '0;
                        r_state <= w_cf ? S_BO : S_HY;
                    end
                end
                S_BO: r_state <= S_BI;
                S_BI: begin
                    r_bo    <= w_band;
                    r_state <= S_BIS;
                end
                S_BIS: begin
                    r_bi    <= w_band;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_in1 || w_in2) begin
                        r_act <= 1'b1;
                        r_fin <= r_i;
                        r_coa <= w_i1;
                        r_num <= w_in1 ? BAND_W'(w_d24 - w_lo) : BAND_W'(w_hi - w_d24);
                        r_den <= w_in1 ? r_bo : r_bi;
                        r_state <= S_DIV;
                    end else begin
                        r_i     <= w_i1;
                        r_state <= w_more ? S_BO : S_HY;
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_dv_ctl.done) begin
                        r_fac   <= w_q;
                        r_state <= S_HY;
                    end
                end
                S_HY: begin
                    r_des <= w_des;
                    r_bnd <= (r_cur < w_des) ? r_cur : w_des;
                    r_up  <= w_des > r_cur;
                    if (w_nl <= 3'd1 || w_nt == 3'd0) begin
                        r_cur   <= '0;
                        r_state <= S_OUT;
                    end else if (w_des == r_cur) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HYM;
                    end
                end
                S_HYM: begin
                    if ({1'b0, r_bnd} >= w_nt || w_bthr == 24'd0) begin
                        r_cur   <= r_des;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HYC;
                    end
                end
                S_HYC: begin
                    if (r_up ? (41'(w_ds) > r_prod[40:0]) : (41'(w_ds) < r_prod[40:0])) begin
                        r_cur <= r_des;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        o_out.level        <= r_cur;
                        o_out.fade_active  <= r_act;
                        o_out.fade_finer   <= r_fin;
                        o_out.fade_coarser <= r_coa;
                        o_out.fade_factor  <= r_fac;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output step");
    a_no_fade_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.fade_active) |-> o_out.fade_factor == 17'd0)
        else $error("blend factor without active band");
    a_level_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_cur))
        else $error("level moved while idle");
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_ctl.done |-> w_q <= 17'd65536)
        else $error("blend factor above one");
endmodule
`default_nettype wire

>>> tb/lod_select_hysteresis_crossfade_test.sv
// Testbench for the distance level-of-detail selector with hysteresis and cross-fade.
`timescale 1ns / 1ps
`default_nettype none
module lod_select_hysteresis_crossfade_test;
    import lsh_pkg::*;

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic signed [23:0] obj_x;
        logic signed [23:0] obj_y;
        logic signed [23:0] obj_z;
    } t_pos;

    typedef struct packed {
        logic [1:0]  level;
        logic        fade_active;
        logic [1:0]  fade_finer;
        logic [1:0]  fade_coarser;
        logic [16:0] fade_factor;
    } t_lod;

    typedef struct {
        int   phase;
        t_pos pos;
        bit   known;
        t_lod lod;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    lsh_in_if  req_ch ();
    lsh_out_if res_ch ();

    lod_select_hysteresis_crossfade i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source)
    );

    // shadow of the block's registers and level
    logic [2:0]  sh_levels;
    logic [2:0]  sh_thr_count;
    logic [23:0] sh_thr [4];
    logic [16:0] sh_fade_width;
    logic        sh_fade_en;
    logic [1:0]  sh_level;

    t_lod lod_pending [$];
    int   errors;
    bit   recv_zero_gap;
    int   recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("lod_select_hysteresis_crossfade_test: errors");
        $finish;
    end

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint band_width(longint seg, longint w);
        longint b;
        if (seg <= 0) return 16777;
        b = seg * w;
        return (b < 16777) ? 64'sd16777 : b;
    endfunction

    function automatic t_lod select_lod(t_pos p);
        t_lod r;
        int nl, nt, lim, want, bnd;
        longint dx, dy, dz, d_len, d24, w, t, prev, nxt, s, bo, bi, t24;
        longint unsigned sq, thr, ds;
        r = '0;
        nl = (sh_levels == 0) ? 1 : (sh_levels > 4) ? 4 : sh_levels;
        nt = (sh_thr_count > 4) ? 4 : sh_thr_count;
        dx = longint'(p.obj_x) - longint'(p.cam_x);
        dy = longint'(p.obj_y) - longint'(p.cam_y);
        dz = longint'(p.obj_z) - longint'(p.cam_z);
        sq = dx * dx + dy * dy + dz * dz;
        d_len = longint'(root_floor(sq));
        if (d_len > 64'hFFFFFF) d_len = 64'hFFFFFF;

        if (sh_fade_en && nl >= 2 && nt > 0) begin
            w = sh_fade_width;
            if (w < 66) w = 66;
            if (w > 65536) w = 65536;
            d24 = d_len << 16;
            for (int i = 0; i + 1 < nl && i < nt; i++) begin
                t = sh_thr[i];
                prev = (i == 0) ? 0 : longint'(sh_thr[i-1]);
                if (i + 1 < nt) begin
                    nxt = sh_thr[i+1];
                end else begin
                    s = t - prev;
                    if (s < 256) s = 256;
                    nxt = t + s * 10;
                end
                bo = band_width(t - prev, w);
                bi = band_width(nxt - t, w);
                t24 = t << 16;
                if (d24 > t24 - bo && d24 <= t24) begin
                    r.fade_active  = 1'b1;
                    r.fade_finer   = i;
                    r.fade_coarser = i + 1;
                    r.fade_factor  = ((d24 - (t24 - bo)) << 16) / bo;
                    break;
                end
                if (d24 > t24 && d24 <= t24 + bi) begin
                    r.fade_active  = 1'b1;
                    r.fade_finer   = i;
                    r.fade_coarser = i + 1;
                    r.fade_factor  = ((t24 + bi - d24) << 16) / bi;
                    break;
                end
            end
        end

        if (nl <= 1 || nt == 0) begin
            sh_level = 0;
        end else begin
            want = nl - 1;
            lim = (nt < nl) ? nt : nl;
            for (int i = 0; i < lim; i++) begin
                if (d_len <= longint'(sh_thr[i])) begin
                    want = i;
                    break;
                end
            end
            if (want != sh_level) begin
                bnd = (sh_level < want) ? sh_level : want;
                thr = sh_thr[bnd & 3];
                ds = d_len << 16;
                if (bnd >= nt || thr == 0) sh_level = want;
                else if (want > sh_level) begin
                    if (ds > thr * 72090) sh_level = want;
                end else if (ds < thr * 58982) sh_level = want;
            end
        end
        r.level = sh_level;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lod got, want;
        if (i_rst_n && req_ch.valid && req_ch.ready)
            lod_pending.push_back(select_lod(t_pos'({req_ch.cam_x, req_ch.cam_y,
                req_ch.cam_z, req_ch.obj_x, req_ch.obj_y, req_ch.obj_z})));
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.level, res_ch.fade_active, res_ch.fade_finer,
                   res_ch.fade_coarser, res_ch.fade_factor};
            if (lod_pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
            end else begin
                want = lod_pending.pop_front();
                if (got.level != want.level || got.fade_active != want.fade_active ||
                    got.fade_finer != want.fade_finer ||
                    got.fade_coarser != want.fade_coarser ||
                    got.fade_factor != want.fade_factor) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls, zero-stall stretches, and one long hold-off
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                stall = recv_hold;
                recv_hold = 0;
            end else begin
                stall = recv_zero_gap ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_LEVEL_COUNT:     sh_levels = data[2:0];
            REG_THRESHOLD_COUNT: sh_thr_count = data[2:0];
            REG_THRESHOLD_0:     sh_thr[0] = data;
            REG_THRESHOLD_1:     sh_thr[1] = data;
            REG_THRESHOLD_2:     sh_thr[2] = data;
            REG_THRESHOLD_3:     sh_thr[3] = data;
            REG_FADE_WIDTH:      sh_fade_width = data[16:0];
            default:             sh_fade_en = data[0];
        endcase
    endtask

    task automatic send_request(t_pos p, bit zero_gap);
        int gap;
        gap = zero_gap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.cam_x = p.cam_x;
        req_ch.cam_y = p.cam_y;
        req_ch.cam_z = p.cam_z;
        req_ch.obj_x = p.obj_x;
        req_ch.obj_y = p.obj_y;
        req_ch.obj_z = p.obj_z;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain;
        req_ch.valid = 1'b0;
        while (lod_pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] axis_pair_cam(longint dlt);
        longint lo, hi;
        lo = (dlt < 0) ? -8388608 - dlt : -8388608;
        hi = (dlt > 0) ? 8388607 - dlt : 8388607;
        return lo + longint'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_pos place(longint span_len);
        t_pos p;
        longint dx, dy, dz;
        dx = span_len;
        if (dx > 16777215) dx = 16777215;
        dy = longint'($urandom_range(0, 64)) - 32;
        dz = longint'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) begin
            {dx, dy} = {dy, dx};
        end
        p.cam_x = axis_pair_cam(dx);
        p.cam_y = axis_pair_cam(dy);
        p.cam_z = axis_pair_cam(dz);
        p.obj_x = p.cam_x + dx;
        p.obj_y = p.cam_y + dy;
        p.obj_z = p.cam_z + dz;
        return p;
    endfunction

    function automatic t_pos random_pos();
        t_pos p;
        longint t, span;
        int n;
        case ($urandom_range(0, 9))
            0, 1: p = t_pos'({$urandom(), $urandom(), $urandom(), $urandom(),
                              16'($urandom())});
            2: p = place($urandom_range(0, 300));
            3: p = place($urandom_range(0, 24'hFFFFFF));
            default: begin
                n = $urandom_range(0, 3);
                t = sh_thr[n];
                span = t / 4 + 300;
                t = t - span + longint'($urandom_range(0, 2 * span));
                p = place((t < 0) ? 0 : t);
            end
        endcase
        return p;
    endfunction

    t_row dir_rows [$];
    t_lod lod_none;

    initial begin
        bit zg;
        longint step;
        int nitems;
        t_pos p;
        logic [23:0] acc;
        int dd [18];
        errors = 0;
        recv_zero_gap = 1'b0;
        recv_hold = 0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_LEVEL_COUNT;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        {req_ch.cam_x, req_ch.cam_y, req_ch.cam_z} = '0;
        {req_ch.obj_x, req_ch.obj_y, req_ch.obj_z} = '0;
        sh_levels = 3'd1;
        sh_thr_count = 3'd0;
        sh_thr = '{default: 24'd0};
        sh_fade_width = 17'd6554;
        sh_fade_en = 1'b0;
        sh_level = 2'd0;
        lod_none = '0;
        dd = '{0, 500, 950, 1000, 1050, 1150, 1200, 2050, 2300, 3100,
               3400, 4100, 4500, 40000, 3500, 2700, 800, 0};

        // after reset: one level, no thresholds, so level zero and no fade
        dir_rows.push_back('{0, t_pos'('0), 1, lod_none});
        dir_rows.push_back('{0, t_pos'({24'h800000, 24'h800000, 24'h800000,
                                        24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}), 1, lod_none});
        dir_rows.push_back('{0, t_pos'({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                        24'h800000, 24'h800000, 24'h800000}), 1, lod_none});
        dir_rows.push_back('{0, t_pos'({24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0}),
                             1, lod_none});
        // four levels, thresholds 1000..4000: walk out and back across bands
        for (int k = 0; k < 18; k++) begin
            dir_rows.push_back('{1, place(dd[k]), 0, lod_none});
        end

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].phase == 1 && (k == 0 || dir_rows[k-1].phase == 0)) begin
                drain();
                write_reg(REG_LEVEL_COUNT, 24'd4);
                write_reg(REG_THRESHOLD_COUNT, 24'd4);
                write_reg(REG_THRESHOLD_0, 24'd1000);
                write_reg(REG_THRESHOLD_1, 24'd2000);
                write_reg(REG_THRESHOLD_2, 24'd3000);
                write_reg(REG_THRESHOLD_3, 24'd4000);
                write_reg(REG_FADE_WIDTH, 24'd65536);
                write_reg(REG_CROSSFADE_EN, 24'd1);
            end
            if (dir_rows[k].known) begin
                if (select_lod(dir_rows[k].pos) != dir_rows[k].lod) begin
                    $display("%0t: table row %0d disagrees with predictor", $time, k);
                    errors++;
                end
                sh_level = dir_rows[k].lod.level;
            end
            send_request(dir_rows[k].pos, 1'b0);
        end

        for (int ph = 0; ph < 14; ph++) begin
            drain();
            write_reg(REG_LEVEL_COUNT, (ph == 0) ? 24'd0 : (ph == 1) ? 24'd7 :
                      (ph < 5) ? 24'd4 : 24'($urandom_range(0, 7)));
            write_reg(REG_THRESHOLD_COUNT, (ph == 2) ? 24'd0 : (ph == 3) ? 24'd7 :
                      24'($urandom_range(0, 7)));
            step = (ph % 3 == 0) ? 64'd8000 : (ph % 3 == 1) ? 64'd400000 : 64'd4000000;
            acc = 0;
            for (int n = 0; n < 4; n++) begin
                if (ph == 5) acc = 24'hFFFFFF;
                else if (ph == 6) acc = (n == 1) ? 24'd0 : 24'($urandom_range(0, 5000));
                else if (ph == 7) acc = 24'($urandom());
                else acc = acc + 24'($urandom_range(0, step));
                write_reg(REG_THRESHOLD_0 + 3'(n), acc);
            end
            write_reg(REG_FADE_WIDTH, (ph == 4) ? 24'd66 : (ph == 8) ? 24'd65536 :
                      (ph == 9) ? 24'd0 : (ph == 10) ? 24'h1FFFF : 24'($urandom_range(0, 17'h1FFFF)));
            write_reg(REG_CROSSFADE_EN, (ph == 11) ? 24'hFFFFFE : 24'($urandom_range(1, 7)));
            if (ph == 6) recv_hold = 400;
            recv_zero_gap = (ph == 12);
            nitems = 105;
            for (int k = 0; k < nitems; k++) begin
                zg = (ph == 6) || (ph == 12) || ((k / 20) % 4 == 3);
                p = random_pos();
                send_request(p, zg);
            end
        end

        req_ch.valid = 1'b0;
        while (lod_pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("lod_select_hysteresis_crossfade_test: clean");
        else
            $display("lod_select_hysteresis_crossfade_test: errors");
        $finish;
    end
endmodule
`default_nettype wire
